// ----- sv/ctema_pkg.sv -----
`default_nettype none

package ctema_pkg;

  // Command codes carried in the request.
  localparam logic CMD_CAPTURE = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  // Register indexes, one 32-bit word each.
  localparam logic [1:0] REG_RATE_CONSTANT = 2'd0;
  localparam logic [1:0] REG_MIN_PERIOD    = 2'd1;
  localparam logic [1:0] REG_STALL_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_EMA_ALPHA     = 2'd3;

  localparam int unsigned PADDR_BITS = 4;

  // Register reset values.
  localparam logic [23:0] RATE_CONSTANT_RST = 24'd600000;
  localparam logic [15:0] MIN_PERIOD_RST    = 16'd50;
  localparam logic [15:0] STALL_TIMEOUT_RST = 16'd4000;
  localparam logic [8:0]  EMA_ALPHA_RST     = 9'd51;

  // Fixed point: alpha of one in Q1.8.
  localparam logic [8:0] Q_ONE = 9'd256;

  // Quotient width of the rpm divide.
  localparam int unsigned QUO_BITS = 24;

  // floor(x / 60) for 16-bit x as (x * 34953) >> 21.
  localparam logic [15:0] SPEED_RECIP = 16'd34953;
  localparam int unsigned SPEED_SHIFT = 21;

  typedef struct packed {
    logic [23:0] rate_constant;
    logic [15:0] min_period;
    logic [15:0] stall_timeout_ms;
    logic [8:0]  ema_alpha_q8;
  } cfg_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] capture_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] rpm;
    logic [10:0] speed;
  } out_item_t;

endpackage

`default_nettype wire

// ----- sv/capture_tachometer_ema.sv -----
// Tachometer from input-capture stamps with exponential smoothing.
// Input channel (in_valid_i / in_ready_o / in_data_i): each request is either
// a capture event carrying a timer stamp or a one millisecond tick.
// Output channel (out_valid_o / out_ready_i / out_data_o): exactly one result
// per request, holding the reported rpm (saturated to 16 bits) and rpm / 60.
// Configuration must be written by the user through the APB port only while
// the block is idle; the block itself does not enforce this. A tick or a
// rejected capture passes from acceptance through the final state into the
// output register. An accepted capture runs, in order, a restoring divide
// for rate_constant / period, the average on one shared multiplier (new
// sample term, old average term, their sum), the state update, then the
// output load. in_ready_o is high only while the sequencer is idle, so a
// new request waits until the previous one is in the output register.
// A waiting result sits in the output register: the next request is taken
// meanwhile, but its result holds in the sequencer until the receiver takes
// the previous one.
// Reset clears the stamp, the average, the reported rpm and the stall
// window, and loads the register defaults. No result is pending after reset.
`default_nettype none

module capture_tachometer_ema #(
  parameter int unsigned STAMP_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire ctema_pkg::in_item_t               in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output ctema_pkg::out_item_t                   out_data_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ctema_pkg::PADDR_BITS-1:0]  paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready
);

  localparam int unsigned SW = STAMP_BITS;
  localparam int unsigned EW = (SW > 16) ? SW : 16;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMA  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  ctema_pkg::cfg_t      cfg;
  ctema_pkg::out_item_t out_q;

  logic [1:0]  state_q;
  logic [SW-1:0] last_stamp_q;
  logic [31:0] smoothed_q;
  logic [23:0] reported_q;
  logic [15:0] elapsed_q;
  logic        pulse_seen_q;
  logic        out_valid_q;

  logic          accept;
  logic [EW-1:0] cap_ext;
  logic [SW-1:0] stamp_now;
  logic [SW-1:0] period;
  logic          period_ok;
  logic [16:0]   elapsed_inc;
  logic          window_end;
  logic          div_start;
  logic          div_done;
  logic [23:0]   instant;
  logic          ema_start;
  logic          ema_done;
  logic [31:0]   ema_res;
  logic          out_free;
  logic [15:0]   rpm_sat;
  logic [31:0]   speed_prod;

  // Configuration registers.
  ctema_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  assign pready = 1'b1;

  // Request decode: period as a modulo difference of stamps.
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign cap_ext     = EW'(in_data_i.capture_value);
  assign stamp_now   = cap_ext[SW-1:0];
  assign period      = stamp_now - last_stamp_q;
  assign period_ok   = EW'(period) > EW'(cfg.min_period);
  assign elapsed_inc = {1'b0, elapsed_q} + 17'd1;
  assign window_end  = elapsed_inc > {1'b0, cfg.stall_timeout_ms};

  assign div_start = accept && (in_data_i.cmd == ctema_pkg::CMD_CAPTURE) && period_ok;
  assign ema_start = (state_q == ST_DIV) && div_done;
  assign out_free  = !out_valid_q || out_ready_i;

  // Divider for rate_constant / period.
  ctema_div #(
    .DIVISOR_BITS (SW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cfg.rate_constant),
    .divisor_i  (period),
    .done_o     (div_done),
    .quotient_o (instant)
  );

  // Exponential average on a shared multiplier.
  ctema_ema u_ema (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ema_start),
    .instant_i  (instant),
    .alpha_i    (cfg.ema_alpha_q8),
    .smoothed_i (smoothed_q),
    .done_o     (ema_done),
    .smoothed_o (ema_res)
  );

  // Sequencer and tachometer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      last_stamp_q <= '0;
      smoothed_q   <= '0;
      reported_q   <= '0;
      elapsed_q    <= '0;
      pulse_seen_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (in_data_i.cmd == ctema_pkg::CMD_CAPTURE) begin
              last_stamp_q <= stamp_now;
              pulse_seen_q <= 1'b1;
              state_q      <= period_ok ? ST_DIV : ST_FIN;
            end else begin
              if (window_end) begin
                if (!pulse_seen_q) begin
                  reported_q <= '0;
                end
                pulse_seen_q <= 1'b0;
                elapsed_q    <= '0;
              end else begin
                elapsed_q <= elapsed_inc[15:0];
              end
              state_q <= ST_FIN;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_EMA;
          end
        end
        ST_EMA: begin
          if (ema_done) begin
            smoothed_q <= ema_res;
            reported_q <= ema_res[31:8];
            state_q    <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Result formation: saturate, then divide by sixty via reciprocal.
  assign rpm_sat    = (|reported_q[23:16]) ? 16'hFFFF : reported_q[15:0];
  assign speed_prod = 32'(rpm_sat) * 32'(ctema_pkg::SPEED_RECIP);

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_FIN) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FIN) && out_free) begin
      out_q.rpm   <= rpm_sat;
      out_q.speed <= speed_prod[ctema_pkg::SPEED_SHIFT +: 11];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // An accepted request takes the sequencer out of idle in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("request accepted but sequencer did not leave idle");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide state");

  // The average only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ema_done |-> (state_q == ST_EMA))
    else $error("average finished outside the average state");

  // Speed is the rpm divided by sixty, floored.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((18'(out_data_o.speed) * 18'd60 <= 18'(out_data_o.rpm)) &&
                     (18'(out_data_o.rpm) < 18'(out_data_o.speed) * 18'd60 + 18'd60)))
    else $error("speed does not match rpm / 60");

endmodule

`default_nettype wire

// ----- sv/ctema_regs.sv -----
`default_nettype none

module ctema_regs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel_i,
  input  wire logic                                penable_i,
  input  wire logic                                pwrite_i,
  input  wire logic [ctema_pkg::PADDR_BITS-1:0]    paddr_i,
  input  wire logic [31:0]                         pwdata_i,
  output logic      [31:0]                         prdata_o,
  output ctema_pkg::cfg_t                          cfg_o
);

  ctema_pkg::cfg_t cfg_q;
  logic            wr_en;
  logic [1:0]      reg_idx;

  assign wr_en   = psel_i && penable_i && pwrite_i;
  assign reg_idx = paddr_i[3:2];

  // Register writes in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate_constant    <= ctema_pkg::RATE_CONSTANT_RST;
      cfg_q.min_period       <= ctema_pkg::MIN_PERIOD_RST;
      cfg_q.stall_timeout_ms <= ctema_pkg::STALL_TIMEOUT_RST;
      cfg_q.ema_alpha_q8     <= ctema_pkg::EMA_ALPHA_RST;
    end else if (wr_en) begin
      case (reg_idx)
        ctema_pkg::REG_RATE_CONSTANT: cfg_q.rate_constant    <= pwdata_i[23:0];
        ctema_pkg::REG_MIN_PERIOD:    cfg_q.min_period       <= pwdata_i[15:0];
        ctema_pkg::REG_STALL_TIMEOUT: cfg_q.stall_timeout_ms <= pwdata_i[15:0];
        ctema_pkg::REG_EMA_ALPHA:     cfg_q.ema_alpha_q8     <= pwdata_i[8:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (reg_idx)
      ctema_pkg::REG_RATE_CONSTANT: prdata_o = {8'd0, cfg_q.rate_constant};
      ctema_pkg::REG_MIN_PERIOD:    prdata_o = {16'd0, cfg_q.min_period};
      ctema_pkg::REG_STALL_TIMEOUT: prdata_o = {16'd0, cfg_q.stall_timeout_ms};
      ctema_pkg::REG_EMA_ALPHA:     prdata_o = {23'd0, cfg_q.ema_alpha_q8};
      default:                      prdata_o = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- sv/ctema_div.sv -----
`default_nettype none

module ctema_div #(
  parameter int unsigned DIVISOR_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [ctema_pkg::QUO_BITS-1:0]    dividend_i,
  input  wire logic [DIVISOR_BITS-1:0]           divisor_i,
  output logic                                   done_o,
  output logic      [ctema_pkg::QUO_BITS-1:0]    quotient_o
);

  localparam int unsigned QB  = ctema_pkg::QUO_BITS;
  localparam int unsigned DW  = (DIVISOR_BITS > QB) ? DIVISOR_BITS : QB;
  localparam int unsigned CNT = $clog2(QB);

  logic              busy_q;
  logic              done_q;
  logic [CNT-1:0]    cnt_q;
  logic [DW:0]       rem_q;
  logic [QB-1:0]     quo_q;
  logic [DIVISOR_BITS-1:0] dvs_q;

  logic [DW:0]       rem_sh;
  logic [DW:0]       dvs_ext;
  logic              fits;

  // One restoring step: shift in the next dividend bit, trial subtract.
  assign rem_sh  = {rem_q[DW-1:0], quo_q[QB-1]};
  assign dvs_ext = (DW+1)'(dvs_q);
  assign fits    = (rem_sh >= dvs_ext);

  // Control: one quotient bit per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT'(QB - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? (rem_sh - dvs_ext) : rem_sh;
      quo_q <= {quo_q[QB-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ----- sv/ctema_ema.sv -----
`default_nettype none

module ctema_ema (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [ctema_pkg::QUO_BITS-1:0]   instant_i,
  input  wire logic [8:0]                       alpha_i,
  input  wire logic [31:0]                      smoothed_i,
  output logic                                  done_o,
  output logic      [31:0]                      smoothed_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_NEW  = 2'd1;
  localparam logic [1:0] PH_OLD  = 2'd2;
  localparam logic [1:0] PH_SUM  = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic        done_q;
  logic [8:0]  alpha_eff;
  logic [8:0]  mul_a;
  logic [31:0] mul_b;
  logic [40:0] prod;
  logic [40:0] term_new_q;
  logic [40:0] term_old_q;
  logic [41:0] sum;
  logic [31:0] res_q;

  // Alpha above one counts as one.
  assign alpha_eff = (alpha_i > ctema_pkg::Q_ONE) ? ctema_pkg::Q_ONE : alpha_i;

  // Shared multiplier: new sample weight first, then old average weight.
  always_comb begin
    case (phase_q)
      PH_NEW: begin
        mul_a = alpha_eff;
        mul_b = 32'(instant_i);
      end
      PH_OLD: begin
        mul_a = ctema_pkg::Q_ONE - alpha_eff;
        mul_b = smoothed_i;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 41'(mul_a) * 41'(mul_b);
  assign sum  = 42'(term_new_q) + 42'(term_old_q);

  // Phase sequencer.
  always_comb begin
    case (phase_q)
      PH_IDLE: phase_d = start_i ? PH_NEW : PH_IDLE;
      PH_NEW:  phase_d = PH_OLD;
      PH_OLD:  phase_d = PH_SUM;
      PH_SUM:  phase_d = PH_IDLE;
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= (phase_q == PH_SUM);
    end
  end

  // Product registers and the Q24.8 result, truncated toward zero.
  always_ff @(posedge clk_i) begin
    if (phase_q == PH_NEW) begin
      term_new_q <= {prod[32:0], 8'd0};
    end
    if (phase_q == PH_OLD) begin
      term_old_q <= prod;
    end
    if (phase_q == PH_SUM) begin
      res_q <= sum[39:8];
    end
  end

  assign done_o     = done_q;
  assign smoothed_o = res_q;

endmodule

`default_nettype wire
